[rtl/core/block_time_difficulty_retarget_assert.svh]
// Assertion macros for the block-time difficulty retarget block.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef BLOCK_TIME_DIFFICULTY_RETARGET_ASSERT_SVH
`define BLOCK_TIME_DIFFICULTY_RETARGET_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BTDR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BTDR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/btdr_pkg.sv]
// Shared types, constants and sequencer program for the difficulty retarget block.
// No dependencies.
package btdr_pkg;

    localparam int TS_W    = 32;
    localparam int DIFF_W  = 7;
    localparam int TGT_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CMP_W   = 34;
    localparam int STEP_W  = 3;

    localparam logic [DIFF_W-1:0] DIFF_MIN     = 7'd8;
    localparam logic [DIFF_W-1:0] DIFF_MAX     = 7'd64;
    localparam logic [DIFF_W-1:0] DIFF_RESET   = 7'd8;
    localparam logic [TGT_W-1:0]  TARGET_RESET = 8'd10;

    // Configuration register indexes
    localparam logic [0:0] REG_INIT_DIFF = 1'b0;
    localparam logic [0:0] REG_TARGET    = 1'b1;

    // Program step addresses
    localparam logic [STEP_W-1:0] STEP_WAIT_IN = 3'd0;
    localparam logic [STEP_W-1:0] STEP_INIT    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SPAN    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_UPDATE  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd5;

    typedef enum logic [4:0] {
        SQ_NEXT     = 5'b00001,
        SQ_WAIT_IN  = 5'b00010,
        SQ_LOOP     = 5'b00100,
        SQ_WAIT_OUT = 5'b01000,
        SQ_GOTO     = 5'b10000
    } seq_op_t;

    typedef struct packed {
        logic              accept;
        logic              scan_init;
        logic              fold;
        logic              take_span;
        logic              update;
        logic              emit;
        seq_op_t           op;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{accept: 1'b0, scan_init: 1'b0, fold: 1'b0, take_span: 1'b0,
               update: 1'b0, emit: 1'b0, op: SQ_GOTO, target: STEP_WAIT_IN};
        case (step)
            STEP_WAIT_IN: begin
                cw.accept = 1'b1;
                cw.op     = SQ_WAIT_IN;
                cw.target = STEP_EMIT;
            end
            STEP_INIT: begin
                cw.scan_init = 1'b1;
                cw.op        = SQ_NEXT;
            end
            STEP_SCAN: begin
                cw.fold = 1'b1;
                cw.op   = SQ_LOOP;
            end
            STEP_SPAN: begin
                cw.take_span = 1'b1;
                cw.op        = SQ_NEXT;
            end
            STEP_UPDATE: begin
                cw.update = 1'b1;
                cw.op     = SQ_NEXT;
            end
            STEP_EMIT: begin
                cw.emit   = 1'b1;
                cw.op     = SQ_WAIT_OUT;
                cw.target = STEP_WAIT_IN;
            end
            default: begin
                cw.op     = SQ_GOTO;
                cw.target = STEP_WAIT_IN;
            end
        endcase
        return cw;
    endfunction

    // Out-of-range starting difficulty loads the floor value.
    function automatic logic [DIFF_W-1:0] clamp_initial(input logic [DIFF_W-1:0] v);
        return (v >= DIFF_MIN && v <= DIFF_MAX) ? v : DIFF_MIN;
    endfunction

endpackage

[rtl/core/block_time_difficulty_retarget.sv]
// While the window fills, an accepted timestamp goes from the wait step straight to emit;
// once it is full, it runs the init, scan, span, update and emit steps, the serial min/max
// scan passing the single read port of the timestamp ring; input is stalled in between.
// A new input is taken while the previous result still waits on the output register.
// Reset (rst_n, async, active low) restores difficulty 8, target 10 and an empty window;
// a write of initial_difficulty restarts the window the same way, with no clearing pass.
module block_time_difficulty_retarget #(
    parameter int WINDOW = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [0:0]                  cfg_index,
    input  logic [btdr_pkg::CFG_W-1:0]  cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [btdr_pkg::TS_W-1:0]   timestamp,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [btdr_pkg::DIFF_W-1:0] difficulty,
    output logic                        window_full
);

    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int SCW = btdr_pkg::TGT_W + AW;

    // ---------------------------------------------------------------
    // Sequencer: step counter addressing the control-word ROM
    // ---------------------------------------------------------------
    logic [btdr_pkg::STEP_W-1:0] step_reg, step_next;
    btdr_pkg::ctrl_word_t        ctrl;

    assign ctrl = btdr_pkg::prog_rom(step_reg);

    // ---------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------
    logic [btdr_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic [btdr_pkg::TGT_W-1:0]  target_reg;
    logic [AW-1:0]               slot_reg;
    logic [CW-1:0]               fill_reg;
    logic                        full_reg;

    // scan datapath
    logic [CW-1:0]               cnt_reg;
    logic [AW-1:0]               rd_addr;
    logic [btdr_pkg::TS_W-1:0]   rd_data_reg;
    logic [btdr_pkg::TS_W-1:0]   min_reg;
    logic [btdr_pkg::TS_W-1:0]   max_reg;
    logic [btdr_pkg::TS_W-1:0]   span_reg;
    logic [SCW-1:0]              scaled_reg;
    logic [btdr_pkg::CMP_W-1:0]  scaled_ext;

    // output register
    logic                        out_valid_reg;
    logic [btdr_pkg::DIFF_W-1:0] out_diff_reg;
    logic                        out_full_reg;

    logic in_take;
    logic init_wr;
    logic out_take;
    logic out_free;
    logic full_after;
    logic scan_done;
    logic rise;
    logic fall;

    // The input is open only in the wait step of the program.
    assign in_stall   = !ctrl.accept;
    assign in_take    = in_valid && ctrl.accept;
    assign init_wr    = cfg_wr_en && (cfg_index == btdr_pkg::REG_INIT_DIFF);
    assign out_take   = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign full_after = (fill_reg >= CW'(WINDOW - 1));
    assign scan_done  = (cnt_reg == CW'(WINDOW));

    // Exact integer forms of the half-target and twice-target average tests.
    assign scaled_ext = btdr_pkg::CMP_W'(scaled_reg);
    assign rise = ({1'b0, span_reg, 1'b0} < scaled_ext);
    assign fall = ({2'b00, span_reg} > {scaled_ext[btdr_pkg::CMP_W-2:0], 1'b0});

    // ---------------------------------------------------------------
    // Next step: conditional jumps from the control word
    // ---------------------------------------------------------------
    always_comb
    begin
        step_next = step_reg;
        case (ctrl.op)
            btdr_pkg::SQ_NEXT:
            begin
                step_next = step_reg + 1'b1;
            end
            btdr_pkg::SQ_WAIT_IN:
            begin
                // full window goes on to the scan, else straight to the result
                if (in_take)
                begin
                    step_next = full_after ? (step_reg + 1'b1) : ctrl.target;
                end
            end
            btdr_pkg::SQ_LOOP:
            begin
                if (scan_done)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            btdr_pkg::SQ_WAIT_OUT:
            begin
                if (out_free)
                begin
                    step_next = ctrl.target;
                end
            end
            btdr_pkg::SQ_GOTO:
            begin
                step_next = ctrl.target;
            end
            default:
            begin
                step_next = btdr_pkg::STEP_WAIT_IN;
            end
        endcase
    end

    // Difficulty moves by one step, within the floor and the cap.
    always_comb
    begin
        diff_next = diff_reg;
        if (ctrl.update)
        begin
            if (rise)
            begin
                if (diff_reg < btdr_pkg::DIFF_MAX)
                begin
                    diff_next = diff_reg + 1'b1;
                end
            end
            else if (fall)
            begin
                if (diff_reg > btdr_pkg::DIFF_MIN)
                begin
                    diff_next = diff_reg - 1'b1;
                end
            end
        end
        // A write of initial_difficulty reloads the level, floor if out of range.
        if (init_wr)
        begin
            diff_next = btdr_pkg::clamp_initial(cfg_data[btdr_pkg::DIFF_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= btdr_pkg::STEP_WAIT_IN;
            diff_reg      <= btdr_pkg::DIFF_RESET;
            target_reg    <= btdr_pkg::TARGET_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            diff_reg <= diff_next;

            // Restart the window on an initial_difficulty write; otherwise advance
            // the ring write slot and the saturating fill count.
            // The user must write configuration only while the block is idle; the block does not enforce it.
            if (init_wr)
            begin
                slot_reg <= '0;
                fill_reg <= '0;
            end
            else if (in_take)
            begin
                slot_reg <= (slot_reg == AW'(WINDOW - 1)) ? '0 : (slot_reg + 1'b1);
                if (fill_reg < CW'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                full_reg <= full_after;
            end

            if (cfg_wr_en && (cfg_index == btdr_pkg::REG_TARGET))
            begin
                target_reg <= cfg_data[btdr_pkg::TGT_W-1:0];
            end

            // Scan counter: address of the next read.
            if (ctrl.scan_init)
            begin
                cnt_reg <= CW'(1);
            end
            else if (ctrl.fold && !scan_done)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // Hold the result until taken; load a new one in the emit step.
            if (ctrl.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Timestamp ring: one write port, one registered read port.
    // Entries are never read before the fill count says they were written.
    // ---------------------------------------------------------------
    logic [btdr_pkg::TS_W-1:0] ring_mem [WINDOW];

    assign rd_addr = ctrl.scan_init ? '0 : cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ring_mem[slot_reg] <= timestamp;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Scan datapath and output payload
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_init)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else if (ctrl.fold)
        begin
            if (rd_data_reg < min_reg)
            begin
                min_reg <= rd_data_reg;
            end
            if (rd_data_reg > max_reg)
            begin
                max_reg <= rd_data_reg;
            end
        end

        if (ctrl.take_span)
        begin
            span_reg   <= max_reg - min_reg;
            scaled_reg <= SCW'(target_reg) * SCW'(WINDOW - 1);
        end

        if (ctrl.emit && out_free)
        begin
            out_diff_reg <= diff_reg;
            out_full_reg <= full_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign difficulty  = out_diff_reg;
    assign window_full = out_full_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "block_time_difficulty_retarget_assert.svh"

    `BTDR_ASSERT(a_diff_range,
        (diff_reg >= btdr_pkg::DIFF_MIN && diff_reg <= btdr_pkg::DIFF_MAX),
        "difficulty left 8..64")
    `BTDR_ASSERT(a_fill_bound, (fill_reg <= CW'(WINDOW)), "fill count beyond window")
    `BTDR_ASSERT_IMPLY(a_out_from_emit, $rose(out_valid_reg),
        ($past(step_reg) == btdr_pkg::STEP_EMIT), "result raised outside emit step")
    `BTDR_ASSERT_IMPLY(a_diff_only_update,
        (!$past(cfg_wr_en) && diff_reg != $past(diff_reg)),
        ($past(step_reg) == btdr_pkg::STEP_UPDATE), "difficulty moved outside update step")
    `BTDR_ASSERT_IMPLY(a_scan_only_full, (step_reg == btdr_pkg::STEP_SCAN),
        (fill_reg == CW'(WINDOW) && full_reg), "scan ran on a partly filled ring")

endmodule

[dv/tb_block_time_difficulty_retarget.sv]
// Self-checking testbench for block_time_difficulty_retarget: timestamp stream in,
// difficulty/window_full out, checked against an in-bench retarget predictor.
// Depends on btdr_pkg and the block_time_difficulty_retarget RTL.
`timescale 1ns / 100ps

module tb_block_time_difficulty_retarget;

    localparam int RING_DEPTH   = 16;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 165;
    localparam int MAX_IDLE     = 18;
    // Worst case per item: full sender gap, full scan latency, full receiver stall,
    // then taken four times over for headroom.
    localparam int CYCLE_LIMIT  = 4 * (PHASES * PHASE_ITEMS + 50) *
                                  (2 * MAX_IDLE + RING_DEPTH + 10);

    // One expected transaction on the result channel
    typedef struct packed {
        logic [btdr_pkg::DIFF_W-1:0] difficulty;
        logic                        full;
    } level_t;

    // Tracks the timestamp ring and difficulty, and matches results in order.
    class retarget_checker;
        logic [btdr_pkg::TS_W-1:0]   ring [RING_DEPTH];
        int                          slot;
        int                          fill;
        logic [btdr_pkg::DIFF_W-1:0] level;
        logic [btdr_pkg::DIFF_W-1:0] start_level;
        logic [btdr_pkg::TGT_W-1:0]  target;
        level_t                      expected_levels [$];
        int                          errors;

        function new();
            start_level = btdr_pkg::DIFF_RESET;
            target      = btdr_pkg::TARGET_RESET;
            errors      = 0;
            restart();
        endfunction

        // Clear the window and reload the starting difficulty, floor if out of range.
        function void restart();
            foreach (ring[i])
                ring[i] = '0;
            slot  = 0;
            fill  = 0;
            level = (start_level >= btdr_pkg::DIFF_MIN && start_level <= btdr_pkg::DIFF_MAX) ?
                    start_level : btdr_pkg::DIFF_MIN;
        endfunction

        function void write_reg(logic [0:0] idx, logic [btdr_pkg::CFG_W-1:0] data);
            if (idx == btdr_pkg::REG_INIT_DIFF)
            begin
                start_level = data[btdr_pkg::DIFF_W-1:0];
                restart();
            end
            else if (idx == btdr_pkg::REG_TARGET)
                target = data[btdr_pkg::TGT_W-1:0];
        endfunction

        // Note an accepted timestamp and queue the result it must produce.
        function void take_stamp(logic [btdr_pkg::TS_W-1:0] ts);
            logic [btdr_pkg::TS_W-1:0]  lo;
            logic [btdr_pkg::TS_W-1:0]  hi;
            logic [btdr_pkg::CMP_W-1:0] span;
            logic [btdr_pkg::CMP_W-1:0] bound;
            level_t                     lvl;
            ring[slot] = ts;
            slot = (slot + 1) % RING_DEPTH;
            if (fill < RING_DEPTH)
                fill++;
            lvl.full = (fill == RING_DEPTH);
            if (lvl.full)
            begin
                lo = '1;
                hi = '0;
                foreach (ring[i])
                begin
                    if (ring[i] < lo)
                        lo = ring[i];
                    if (ring[i] > hi)
                        hi = ring[i];
                end
                span  = {2'b00, hi - lo};
                bound = btdr_pkg::CMP_W'(target) * btdr_pkg::CMP_W'(RING_DEPTH - 1);
                if ((span << 1) < bound)
                begin
                    if (level < btdr_pkg::DIFF_MAX)
                        level++;
                end
                else if (span > (bound << 1))
                begin
                    if (level > btdr_pkg::DIFF_MIN)
                        level--;
                end
            end
            lvl.difficulty = level;
            expected_levels.push_back(lvl);
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_level(logic [btdr_pkg::DIFF_W-1:0] got_diff, logic got_full);
            level_t want;
            if (expected_levels.size() == 0)
            begin
                report($sformatf("unexpected result: difficulty %0d window_full %0b",
                                 got_diff, got_full));
                return;
            end
            want = expected_levels.pop_front();
            if (got_diff !== want.difficulty)
                report($sformatf("difficulty %0d, want %0d", got_diff, want.difficulty));
            if (got_full !== want.full)
                report($sformatf("window_full %0b, want %0b", got_full, want.full));
        endtask

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [0:0]                    cfg_index;
    logic [btdr_pkg::CFG_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [btdr_pkg::TS_W-1:0]     timestamp;
    logic                          out_valid;
    logic                          out_stall;
    logic [btdr_pkg::DIFF_W-1:0]   difficulty;
    logic                          window_full;

    retarget_checker      sb = new();
    int                   cycle_count = 0;
    bit                   quiet_in;
    bit                   quiet_out;
    int                   cur_target = btdr_pkg::TARGET_RESET;

    block_time_difficulty_retarget #(
        .WINDOW(RING_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .timestamp   (timestamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .difficulty  (difficulty),
        .window_full (window_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("block_time_difficulty_retarget: mismatch");
            $finish;
        end
    end

    // Monitor both channels at the clock edge. Check the outgoing result before noting
    // the incoming timestamp: a new input may be taken in the same cycle that the
    // previous result leaves, and that result belongs to the older transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_level(difficulty, window_full);
            if (in_valid && !in_stall)
                sb.take_stamp(timestamp);
        end
    end

    // Receiver backpressure: after each accepted result, draw a stall for the next one.
    // The stall runs in its own process, independent of which program step the block is in.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                n = quiet_out ? 0 : $urandom_range(0, MAX_IDLE);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Write one register; hold the enable for exactly one edge, then drop it.
    task write_reg(input logic [0:0] idx, input logic [btdr_pkg::CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        if (idx == btdr_pkg::REG_TARGET)
            cur_target = data;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one timestamp after a random gap and hold it until the block takes it.
    // Valid stays high across back-to-back transactions, so it is only dropped
    // when a gap follows.
    task send_stamp(input logic [btdr_pkg::TS_W-1:0] ts);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        timestamp <= ts;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [btdr_pkg::CFG_W-1:0] init_list [6];
        logic [btdr_pkg::CFG_W-1:0] tgt_list [6];
        logic [btdr_pkg::TS_W-1:0]  stamp;
        logic [btdr_pkg::TS_W-1:0]  ts;
        int                         mode;
        int                         unit;

        // Extremes first: top of range, floor, zero and all-ones (both load the floor),
        // just below and just above the legal window.
        init_list = '{8'd64, 8'd8, 8'd0, 8'hFF, 8'd7, 8'd65};
        tgt_list  = '{8'd255, 8'd1, 8'd0, 8'd10, 8'd128, 8'd3};

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= btdr_pkg::REG_INIT_DIFF;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        timestamp <= '0;
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the window with identical stamps (no adjustment while filling,
        // then a zero span raises the level), then the widest possible span lowers it
        // and hits the floor, then stamps arriving out of order.
        repeat (RING_DEPTH)
            send_stamp(32'h0000_0000);
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'h0000_03E8);
        send_stamp(32'h0000_0005);
        send_stamp(32'h7FFF_FFFF);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            // Some phases run with no idling at all on one side or the other.
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            if (p < 6)
            begin
                write_reg(btdr_pkg::REG_INIT_DIFF, init_list[p]);
                write_reg(btdr_pkg::REG_TARGET, tgt_list[p]);
            end
            else
            begin
                // A target-only write must leave the window as it is.
                if ($urandom_range(0, 1) == 1)
                    write_reg(btdr_pkg::REG_INIT_DIFF,
                              btdr_pkg::CFG_W'($urandom_range(0, 255)));
                write_reg(btdr_pkg::REG_TARGET, btdr_pkg::CFG_W'($urandom_range(0, 255)));
            end

            // Start some phases just below the 32-bit wrap.
            stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
            mode  = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 20 == 0)
                    mode = $urandom_range(0, 9);
                unit = (cur_target == 0) ? 1 : cur_target;
                // Step sizes aim the window span below, between and above the
                // rise and fall thresholds.
                case (mode)
                    0, 1, 2: stamp = stamp + $urandom_range(0, unit / 2);
                    3, 4:    stamp = stamp + $urandom_range(unit / 2, 2 * unit);
                    5, 6:    stamp = stamp + $urandom_range(2 * unit, 3 * unit);
                    7:       stamp = stamp + $urandom_range(0, 4 * unit);
                    default: ;
                endcase
                if (mode == 8)
                    ts = stamp + $urandom_range(0, 2 * unit) - unit;
                else if (mode == 9)
                    ts = $urandom;
                else
                    ts = stamp;
                send_stamp(ts);
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
            settle();
        end

        // Let any late activity show up before the verdict.
        repeat (RING_DEPTH + 15) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("block_time_difficulty_retarget: match");
        else
            $display("block_time_difficulty_retarget: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/btdr_pkg.sv
rtl/core/block_time_difficulty_retarget.sv
dv/tb_block_time_difficulty_retarget.sv
